// ----- design/projected_point_bounding_box_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the projected point bounding box core
// Concurrent checks on clk_i, held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef PROJECTED_POINT_BOUNDING_BOX_CORE_MACROS_SVH
`define PROJECTED_POINT_BOUNDING_BOX_CORE_MACROS_SVH

// property must hold at every clock edge
`define PBB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// condition must never be true
`define PBB_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// ----- design/pbb_pkg.sv -----
// ----------------------------------------------------------------------------
// Projected point bounding box package
// Shared constants, register codes, state types and helpers.
// ----------------------------------------------------------------------------
package pbb_pkg;

  localparam int CoordWidthDef   = 16;
  localparam int MaxScreenDimDef = 4096;

  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 16;
  localparam int ScaleW   = 16;
  localparam int CamW     = 16;
  localparam int RegDimW  = 13;
  localparam int NearW    = 8;

  localparam int PosW      = 24;
  localparam int QuotW     = 24;
  localparam int LeftW     = 15;
  localparam int RightW    = 16;
  localparam int OutTdataW = 64;

  localparam logic signed [PosW-1:0] PosMax = 24'sh7FFFFF;
  localparam logic signed [PosW-1:0] PosMin = 24'sh800000;

  typedef enum logic [2:0] {
    REG_CAMERA_X,
    REG_CAMERA_Y,
    REG_CAMERA_Z,
    REG_SCALE_X,
    REG_SCALE_Y,
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT,
    REG_NEAR_LIMIT
  } pbb_reg_e;

  localparam logic [CamW-1:0]    CamXRst   = 16'h0000;
  localparam logic [CamW-1:0]    CamYRst   = 16'h0180;
  localparam logic [CamW-1:0]    CamZRst   = 16'hFE00;
  localparam logic [ScaleW-1:0]  ScaleXRst = 16'd3909;
  localparam logic [ScaleW-1:0]  ScaleYRst = 16'd7094;
  localparam logic [RegDimW-1:0] WidthRst  = 13'd1960;
  localparam logic [RegDimW-1:0] HeightRst = 13'd1080;
  localparam logic [NearW-1:0]   NearRst   = 8'd0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_FINISH
  } pbb_state_e;

  typedef enum logic [2:0] {
    LN_IDLE,
    LN_MUL1,
    LN_MUL2,
    LN_PREP,
    LN_DIV,
    LN_FIN
  } pbb_lane_state_e;

  // Q.8 to integer, rounding toward zero
  function automatic logic signed [RightW-1:0] pbb_trunc_q8(logic signed [PosW-1:0] v);
    logic signed [PosW-1:0] b;
    b = v[PosW-1] ? (v + 24'sd255) : v;
    return b[PosW-1:8];
  endfunction

endpackage

// ----- design/pbb_lane.sv -----
// ----------------------------------------------------------------------------
// Projection lane
// Bit-serial scale*dim and magnitude multiplies, restoring divide by the
// depth, floor correction, screen offset and 24 bit saturation.
// ----------------------------------------------------------------------------
module pbb_lane #(
  parameter int MAG_W = 16,
  parameter int DIM_W = 13,
  parameter int DEN_W = 21
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic                              neg_i,
  input  logic [MAG_W-1:0]                  mag_i,
  input  logic [pbb_pkg::ScaleW-1:0]        scale_i,
  input  logic [DIM_W-1:0]                  dim_i,
  input  logic [DEN_W-1:0]                  den_i,
  output logic                              done_o,
  output logic signed [pbb_pkg::PosW-1:0]   pos_o
);
  import pbb_pkg::*;

  localparam int P1W   = DIM_W + ScaleW;
  localparam int NW    = P1W + MAG_W;
  localparam int HiW   = NW - QuotW;
  localparam int CmpW  = (HiW > DEN_W) ? HiW : DEN_W;
  localparam int MaxIt = (MAG_W > QuotW) ? MAG_W : QuotW;
  localparam int CntW  = $clog2(MaxIt);
  localparam int SumW  = PosW + 2;

  localparam logic signed [SumW-1:0] SumMax = SumW'(PosMax);
  localparam logic signed [SumW-1:0] SumMin = SumW'(PosMin);

  pbb_lane_state_e state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             done_q, done_d;
  logic             neg_q, neg_d;
  logic             ovf_q, ovf_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [P1W-1:0]   p1_q, p1_d;
  logic [NW-1:0]    n_q, n_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [QuotW-1:0] qn_q, qn_d;
  logic signed [PosW-1:0] pos_q, pos_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      LN_IDLE: if (start_i) state_d = LN_MUL1;
      LN_MUL1: if (cnt_q == '0) state_d = LN_MUL2;
      LN_MUL2: if (cnt_q == '0) state_d = LN_PREP;
      LN_PREP: state_d = LN_DIV;
      LN_DIV:  if (cnt_q == '0) state_d = LN_FIN;
      LN_FIN:  state_d = LN_IDLE;
      default: state_d = LN_IDLE;
    endcase
  end

  always_comb begin
    logic [DIM_W:0]         p1_hi;
    logic [P1W:0]           n_hi;
    logic [DEN_W:0]         trial;
    logic [DEN_W:0]         diff;
    logic                   ge;
    logic [DIM_W-1:0]       dim_m1;
    logic signed [SumW-1:0] qmag;
    logic signed [SumW-1:0] qval;
    logic signed [SumW-1:0] off;
    logic signed [SumW-1:0] sum;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    ovf_d  = ovf_q;
    den_d  = den_q;
    p1_d   = p1_q;
    n_d    = n_q;
    rem_d  = rem_q;
    qn_d   = qn_q;
    pos_d  = pos_q;
    p1_hi  = '0;
    n_hi   = '0;
    trial  = '0;
    diff   = '0;
    ge     = 1'b0;
    dim_m1 = '0;
    qmag   = '0;
    qval   = '0;
    off    = '0;
    sum    = '0;
    case (state_q)
      LN_IDLE: begin
        if (start_i) begin
          neg_d = neg_i;
          den_d = den_i;
          n_d   = {{P1W{1'b0}}, mag_i};
          p1_d  = {{DIM_W{1'b0}}, scale_i};
          cnt_d = CntW'(ScaleW - 1);
        end
      end
      LN_MUL1: begin
        p1_hi = {1'b0, p1_q[P1W-1:ScaleW]} + (p1_q[0] ? {1'b0, dim_i} : '0);
        p1_d  = {p1_hi, p1_q[ScaleW-1:1]};
        cnt_d = (cnt_q == '0) ? CntW'(MAG_W - 1) : cnt_q - 1'b1;
      end
      LN_MUL2: begin
        n_hi  = {1'b0, n_q[NW-1:MAG_W]} + (n_q[0] ? {1'b0, p1_q} : '0);
        n_d   = {n_hi, n_q[MAG_W-1:1]};
        cnt_d = cnt_q - 1'b1;
      end
      LN_PREP: begin
        ovf_d = CmpW'(n_q[NW-1:QuotW]) >= CmpW'(den_q);
        rem_d = DEN_W'(n_q[NW-1:QuotW]);
        qn_d  = n_q[QuotW-1:0];
        cnt_d = CntW'(QuotW - 1);
      end
      LN_DIV: begin
        trial = {rem_q, qn_q[QuotW-1]};
        diff  = trial - {1'b0, den_q};
        ge    = trial >= {1'b0, den_q};
        rem_d = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        qn_d  = {qn_q[QuotW-2:0], ge};
        cnt_d = cnt_q - 1'b1;
      end
      LN_FIN: begin
        qmag   = $signed({2'b00, qn_q});
        qval   = neg_q ? (-qmag - $signed({{(SumW-1){1'b0}}, |rem_q})) : qmag;
        dim_m1 = dim_i - DIM_W'(1);
        off    = $signed(SumW'({dim_m1, 7'b0}));
        sum    = qval + off;
        if (ovf_q) begin
          pos_d = neg_q ? PosMin : PosMax;
        end else if (sum > SumMax) begin
          pos_d = PosMax;
        end else if (sum < SumMin) begin
          pos_d = PosMin;
        end else begin
          pos_d = sum[PosW-1:0];
        end
        done_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LN_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    ovf_q <= ovf_d;
    den_q <= den_d;
    p1_q  <= p1_d;
    n_q   <= n_d;
    rem_q <= rem_d;
    qn_q  <= qn_d;
    pos_q <= pos_d;
  end

  assign done_o = done_q;
  assign pos_o  = pos_q;

endmodule

// ----- design/projected_point_bounding_box_core.sv -----
// ----------------------------------------------------------------------------
// Projected point bounding box core
// Projects camera-relative points to screen space and emits their box.
// ----------------------------------------------------------------------------
// channel   dir  handshake                  payload
// s_axis    in   s_axis_tvalid/tready       tdata: point x,y,z; tlast: last point
// m_axis    out  m_axis_tvalid/tready       tdata: box l,t,r,b; tuser: box valid
// cfg       in   cfg_valid_i/cfg_ready_o    cfg_addr_i: register, cfg_data_i: value
//
// A visible point passes 16 steps of the scale*dimension multiply, the magnitude multiply
// one bit per cycle and 24 restoring divide steps, x and y in two lanes in lockstep.
// A point at or behind the near limit bypasses the lanes.
// Reset loads register defaults; the min/max store needs no clearing.
// The box waits in the output register while input continues; a last point
// stalls only while a previous box is still pending.
// ----------------------------------------------------------------------------
`include "projected_point_bounding_box_core_macros.svh"

module projected_point_bounding_box_core #(
  parameter int  COORD_WIDTH    = pbb_pkg::CoordWidthDef,
  parameter int  MAX_SCREEN_DIM = pbb_pkg::MaxScreenDimDef,
  localparam int InTdataW       = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // point_x, point_y, point_z (COORD_WIDTH each), zero pad
  input  logic [InTdataW-1:0]             s_axis_tdata,
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // box_left[14:0], box_top[29:15], box_right[45:30], box_bottom[61:46], zero pad
  output logic [pbb_pkg::OutTdataW-1:0]   m_axis_tdata,
  // box_valid
  output logic                            m_axis_tuser,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pbb_pkg::CfgAddrW-1:0]    cfg_addr_i,
  input  logic [pbb_pkg::CfgDataW-1:0]    cfg_data_i
);
  import pbb_pkg::*;

  localparam int CW      = COORD_WIDTH;
  localparam int DW      = ((CW > CamW) ? CW : CamW) + 1;
  localparam int MagW    = DW - 1;
  localparam int DenW    = DW + 4;
  localparam int DimW    = $clog2(MAX_SCREEN_DIM + 1);
  localparam int DimCmpW = (DimW > RegDimW) ? DimW : RegDimW;

  logic [CamW-1:0]    cam_x_q, cam_y_q, cam_z_q;
  logic [ScaleW-1:0]  scale_x_q, scale_y_q;
  logic [RegDimW-1:0] width_q, height_q;
  logic [NearW-1:0]   near_q;

  pbb_state_e state_q, state_d;
  logic last_q, last_d;
  logic seen_q, seen_d;
  logic signed [PosW-1:0] min_x_q, max_x_q, min_y_q, max_y_q;
  logic signed [PosW-1:0] min_x_d, max_x_d, min_y_d, max_y_d;
  logic                   m_valid_q, m_valid_d;
  logic [OutTdataW-1:0]   m_data_q, m_data_d;
  logic                   m_user_q, m_user_d;

  logic [DimW-1:0] w_dim, h_dim, w_m1, h_m1;
  logic signed [DW-1:0] cx, cy, cz;
  logic [MagW-1:0] mag_x, mag_y;
  logic [DenW-1:0] den;
  logic neg_x, neg_y, visible, accept;
  logic lane_start, out_load;
  logic x_done, y_done;
  logic signed [PosW-1:0] x_pos, y_pos;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q   <= CamXRst;
      cam_y_q   <= CamYRst;
      cam_z_q   <= CamZRst;
      scale_x_q <= ScaleXRst;
      scale_y_q <= ScaleYRst;
      width_q   <= WidthRst;
      height_q  <= HeightRst;
      near_q    <= NearRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (pbb_reg_e'(cfg_addr_i))
        REG_CAMERA_X:     cam_x_q   <= cfg_data_i;
        REG_CAMERA_Y:     cam_y_q   <= cfg_data_i;
        REG_CAMERA_Z:     cam_z_q   <= cfg_data_i;
        REG_SCALE_X:      scale_x_q <= cfg_data_i;
        REG_SCALE_Y:      scale_y_q <= cfg_data_i;
        REG_IMAGE_WIDTH:  width_q   <= cfg_data_i[RegDimW-1:0];
        REG_IMAGE_HEIGHT: height_q  <= cfg_data_i[RegDimW-1:0];
        REG_NEAR_LIMIT:   near_q    <= cfg_data_i[NearW-1:0];
      endcase
    end
  end

  // screen dimensions saturated into 1..MAX_SCREEN_DIM
  always_comb begin
    logic [DimCmpW-1:0] we;
    logic [DimCmpW-1:0] he;
    we = DimCmpW'(width_q);
    he = DimCmpW'(height_q);
    if (we == '0) w_dim = DimW'(1);
    else if (we > DimCmpW'(MAX_SCREEN_DIM)) w_dim = DimW'(MAX_SCREEN_DIM);
    else w_dim = DimW'(we);
    if (he == '0) h_dim = DimW'(1);
    else if (he > DimCmpW'(MAX_SCREEN_DIM)) h_dim = DimW'(MAX_SCREEN_DIM);
    else h_dim = DimW'(he);
    w_m1 = w_dim - DimW'(1);
    h_m1 = h_dim - DimW'(1);
  end

  // camera-relative point
  always_comb begin
    logic [CW-1:0] px, py, pz;
    px = s_axis_tdata[CW-1:0];
    py = s_axis_tdata[2*CW-1:CW];
    pz = s_axis_tdata[3*CW-1:2*CW];
    cx = $signed({{(DW-CW){px[CW-1]}}, px}) - $signed({{(DW-CamW){cam_x_q[CamW-1]}}, cam_x_q});
    cy = $signed({{(DW-CW){py[CW-1]}}, py}) - $signed({{(DW-CamW){cam_y_q[CamW-1]}}, cam_y_q});
    cz = $signed({{(DW-CW){pz[CW-1]}}, pz}) - $signed({{(DW-CamW){cam_z_q[CamW-1]}}, cam_z_q});
    visible = cz > $signed({{(DW-NearW){1'b0}}, near_q});
    neg_x   = cx[DW-1];
    neg_y   = ~cy[DW-1];
    mag_x   = cx[DW-1] ? MagW'(-cx) : MagW'(cx);
    mag_y   = cy[DW-1] ? MagW'(-cy) : MagW'(cy);
    den     = {cz[MagW-1:0], 5'b0};
  end

  pbb_lane #(
    .MAG_W (MagW),
    .DIM_W (DimW),
    .DEN_W (DenW)
  ) u_lane_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lane_start),
    .neg_i   (neg_x),
    .mag_i   (mag_x),
    .scale_i (scale_x_q),
    .dim_i   (w_dim),
    .den_i   (den),
    .done_o  (x_done),
    .pos_o   (x_pos)
  );

  pbb_lane #(
    .MAG_W (MagW),
    .DIM_W (DimW),
    .DEN_W (DenW)
  ) u_lane_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lane_start),
    .neg_i   (neg_y),
    .mag_i   (mag_y),
    .scale_i (scale_y_q),
    .dim_i   (h_dim),
    .den_i   (den),
    .done_o  (y_done),
    .pos_o   (y_pos)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) state_d = visible ? ST_CALC : ST_FINISH;
      end
      ST_CALC: if (x_done) state_d = ST_FINISH;
      ST_FINISH: begin
        if (!last_q || !m_valid_q || m_axis_tready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    accept        = s_axis_tvalid && s_axis_tready;
    lane_start    = accept && visible;
    out_load      = (state_q == ST_FINISH) && last_q && (!m_valid_q || m_axis_tready);
  end

  // running box and output word
  always_comb begin
    logic signed [RightW-1:0] l16, t16, r16, b16;
    logic [LeftW-1:0]  left, top;
    logic [RightW-1:0] right, bottom;
    last_d    = accept ? s_axis_tlast : last_q;
    seen_d    = seen_q;
    min_x_d   = min_x_q;
    max_x_d   = max_x_q;
    min_y_d   = min_y_q;
    max_y_d   = max_y_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;

    l16 = pbb_trunc_q8(min_x_q);
    t16 = pbb_trunc_q8(min_y_q);
    r16 = pbb_trunc_q8(max_x_q);
    b16 = pbb_trunc_q8(max_y_q);
    left   = l16[RightW-1] ? '0 : l16[LeftW-1:0];
    top    = t16[RightW-1] ? '0 : t16[LeftW-1:0];
    right  = ($signed({r16[RightW-1], r16}) > $signed((RightW+1)'(w_m1))) ?
             RightW'(w_m1) : r16;
    bottom = ($signed({b16[RightW-1], b16}) > $signed((RightW+1)'(h_m1))) ?
             RightW'(h_m1) : b16;

    if (x_done) begin
      seen_d = 1'b1;
      if (!seen_q || (x_pos < min_x_q)) min_x_d = x_pos;
      if (!seen_q || (x_pos > max_x_q)) max_x_d = x_pos;
      if (!seen_q || (y_pos < min_y_q)) min_y_d = y_pos;
      if (!seen_q || (y_pos > max_y_q)) max_y_d = y_pos;
    end

    if (m_axis_tready) m_valid_d = 1'b0;
    if (out_load) begin
      m_valid_d = 1'b1;
      m_user_d  = seen_q;
      m_data_d  = seen_q ? {2'b00, bottom, right, top, left} : '0;
      seen_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      last_q    <= 1'b0;
      seen_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      last_q    <= last_d;
      seen_q    <= seen_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    min_x_q  <= min_x_d;
    max_x_q  <= max_x_d;
    min_y_q  <= min_y_d;
    max_y_q  <= max_y_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  `PBB_ASSERT(a_lanes_lockstep, x_done == y_done, "x and y lanes out of step")
  `PBB_ASSERT(a_done_in_calc, x_done |-> (state_q == ST_CALC), "lane result outside calc")
  `PBB_ASSERT(a_clear_after_box, out_load |=> !seen_q, "box state not cleared")
  `PBB_ASSERT_NEVER(a_empty_box_zero, m_axis_tvalid && !m_axis_tuser && (m_axis_tdata != '0), "empty box not zero")

endmodule

// ----- test/tb_projected_point_bounding_box_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the projected point bounding box core
// Streams point sets through the core under several register settings and
// handshake pressures. A local model folds every accepted point word into
// a running screen box and queues the box predicted on each last point. A
// monitor compares every output word, field by field, with the oldest box.
// ----------------------------------------------------------------------------
module tb_projected_point_bounding_box_core;
  import pbb_pkg::*;

  localparam int CycleLimit   = 1000000;
  localparam int SettleCycles = 100;
  localparam int PhaseTarget  = 172;
  localparam int RandomPhases = 8;
  localparam int InW          = 3 * CoordWidthDef;

  typedef struct packed {
    logic [LeftW-1:0]         left;
    logic [LeftW-1:0]         top;
    logic signed [RightW-1:0] right;
    logic signed [RightW-1:0] bottom;
    logic                     valid;
  } box_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InW-1:0]       s_axis_tdata  = '0;
  logic                 s_axis_tlast  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgAddrW-1:0]  cfg_addr_i    = '0;
  logic [CfgDataW-1:0]  cfg_data_i    = '0;

  // register shadow
  logic signed [CamW-1:0] cam_x     = CamXRst;
  logic signed [CamW-1:0] cam_y     = CamYRst;
  logic signed [CamW-1:0] cam_z     = CamZRst;
  logic [ScaleW-1:0]      scale_x_q = ScaleXRst;
  logic [ScaleW-1:0]      scale_y_q = ScaleYRst;
  logic [RegDimW-1:0]     width_q   = WidthRst;
  logic [RegDimW-1:0]     height_q  = HeightRst;
  logic [NearW-1:0]       near_q    = NearRst;

  // running box in Q.8 screen units
  longint min_x, max_x, min_y, max_y;
  bit     any_hit = 1'b0;

  box_t   expected_boxes[$];
  int     projected_count = 0;
  int     mismatch_count  = 0;
  int     box_count       = 0;
  int     src_idle_pct    = 0;
  int     sink_stall_pct  = 0;

  projected_point_bounding_box_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  function automatic longint screen_dim(logic [RegDimW-1:0] r);
    longint d;
    d = longint'(r);
    if (d < 1) d = 1;
    if (d > MaxScreenDimDef) d = MaxScreenDimDef;
    return d;
  endfunction

  function automatic longint floor_quot(longint n, longint d);
    longint q;
    q = n / d;
    if (n % d != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint clamp_pos(longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  task automatic fold_point(input logic signed [CoordWidthDef-1:0] px, py, pz,
                            input logic last_pt);
    longint w, h, cx, cy, cz, sx, sy, l, t, r, b;
    box_t   bx;
    w  = screen_dim(width_q);
    h  = screen_dim(height_q);
    cx = longint'(px) - longint'(cam_x);
    cy = longint'(py) - longint'(cam_y);
    cz = longint'(pz) - longint'(cam_z);
    if (cz > longint'(near_q) && cz >= 1) begin
      projected_count++;
      sx = clamp_pos(floor_quot(cx * longint'(scale_x_q) * w, cz * 32) + 128 * w - 128);
      sy = clamp_pos(floor_quot(-cy * longint'(scale_y_q) * h, cz * 32) + 128 * h - 128);
      if (!any_hit) begin
        min_x   = sx;
        max_x   = sx;
        min_y   = sy;
        max_y   = sy;
        any_hit = 1'b1;
      end else begin
        if (sx < min_x) min_x = sx;
        if (sx > max_x) max_x = sx;
        if (sy < min_y) min_y = sy;
        if (sy > max_y) max_y = sy;
      end
    end
    if (last_pt) begin
      bx = '0;
      if (any_hit) begin
        // division truncates toward zero
        l = min_x / 256;
        t = min_y / 256;
        r = max_x / 256;
        b = max_y / 256;
        if (l < 0) l = 0;
        if (t < 0) t = 0;
        if (r > w - 1) r = w - 1;
        if (b > h - 1) b = h - 1;
        bx.left   = LeftW'(l);
        bx.top    = LeftW'(t);
        bx.right  = RightW'(r);
        bx.bottom = RightW'(b);
        bx.valid  = 1'b1;
      end
      expected_boxes = {expected_boxes, bx};
      any_hit = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    $display("mismatch at box word %0d, %s: got %0d, expected %0d",
             box_count, what, got, want);
  endtask

  always @(posedge clk_i) begin : box_monitor
    box_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      box_count++;
      if (expected_boxes.size() == 0) begin
        report_mismatch("word with no box pending", m_axis_tdata[61:0], 0);
      end else begin
        want = expected_boxes.pop_front();
        if (m_axis_tdata[14:0] !== want.left)
          report_mismatch("left", m_axis_tdata[14:0], want.left);
        if (m_axis_tdata[29:15] !== want.top)
          report_mismatch("top", m_axis_tdata[29:15], want.top);
        if (m_axis_tdata[45:30] !== want.right)
          report_mismatch("right", $signed(m_axis_tdata[45:30]), want.right);
        if (m_axis_tdata[61:46] !== want.bottom)
          report_mismatch("bottom", $signed(m_axis_tdata[61:46]), want.bottom);
        if (m_axis_tuser !== want.valid)
          report_mismatch("valid", m_axis_tuser, want.valid);
      end
    end
  end

  // called at a falling edge; leaves tvalid high for the next word
  task automatic send_point(input logic signed [CoordWidthDef-1:0] px, py, pz,
                            input logic last_pt);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pz, py, px};
    s_axis_tlast  <= last_pt;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    fold_point(px, py, pz, last_pt);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_boxes.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic program_regs(input logic [CfgDataW-1:0] cx_v, cy_v, cz_v, sx_v, sy_v,
                              input logic [CfgDataW-1:0] w_v, h_v, near_v);
    logic [CfgDataW-1:0] vals [8];
    pbb_reg_e            reg_id;
    vals = '{cx_v, cy_v, cz_v, sx_v, sy_v, w_v, h_v, near_v};
    for (int i = 0; i <= int'(REG_NEAR_LIMIT); i++) begin
      reg_id      = pbb_reg_e'(i);
      cfg_valid_i <= 1'b1;
      cfg_addr_i  <= reg_id;
      cfg_data_i  <= vals[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      case (reg_id)
        REG_CAMERA_X:     cam_x     = vals[i];
        REG_CAMERA_Y:     cam_y     = vals[i];
        REG_CAMERA_Z:     cam_z     = vals[i];
        REG_SCALE_X:      scale_x_q = vals[i];
        REG_SCALE_Y:      scale_y_q = vals[i];
        REG_IMAGE_WIDTH:  width_q   = vals[i][RegDimW-1:0];
        REG_IMAGE_HEIGHT: height_q  = vals[i][RegDimW-1:0];
        REG_NEAR_LIMIT:   near_q    = vals[i][NearW-1:0];
        default: ;
      endcase
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_point(0, 0, 0, 1'b0);
    send_point(256, -256, 256, 1'b0);
    send_point(-512, 512, -256, 1'b1);
    // depth zero only: empty box
    send_point(0, 0, -512, 1'b1);
    send_point(0, 384, -511, 1'b1);
    wait_idle();
  endtask

  task automatic test_near_limit();
    program_regs(0, 0, 0, 4096, 4096, 640, 480, 255);
    send_point(0, 0, 255, 1'b0);
    send_point(100, -100, 256, 1'b0);
    send_point(0, 0, -300, 1'b0);
    send_point(-200, 50, 1000, 1'b1);
    send_point(0, 0, 255, 1'b1);
    wait_idle();
  endtask

  task automatic test_field_extremes();
    program_regs(0, 0, 16'h8000, 16'hFFFF, 16'hFFFF, 4096, 4096, 0);
    send_point(-32768, -32768, 32767, 1'b0);
    send_point(32767, 32767, 32767, 1'b0);
    send_point(0, 0, -32767, 1'b1);
    send_point(32767, -32768, -32768, 1'b1);
    // depth one with far lateral offset saturates
    send_point(-32768, 32767, -32767, 1'b1);
    wait_idle();
  endtask

  task automatic test_screen_limits();
    // width register zero, height register above the screen limit
    program_regs(0, 0, 0, 0, 16'hFFFF, 0, 16'h1FFF, 0);
    send_point(1000, -1000, 256, 1'b0);
    send_point(-1000, 1000, 512, 1'b1);
    send_point(32767, 32767, 1, 1'b1);
    wait_idle();
    program_regs(16'h8000, 16'h7FFF, 16'h7FFF, 16'hFFFF, 0, 4096, 1, 0);
    send_point(0, 0, 32767, 1'b1);
    send_point(-32768, 32767, -32768, 1'b1);
    wait_idle();
  endtask

  task automatic test_random_sets();
    int                             start_count, set_len, kind, cxr, cyr, czr;
    logic signed [CoordWidthDef-1:0] px, py, pz;
    for (int p = 0; p < RandomPhases; p++) begin
      case (p)
        0: program_regs(CamXRst, CamYRst, CamZRst, ScaleXRst, ScaleYRst,
                        WidthRst, HeightRst, NearRst);
        1: program_regs(16'h8000, 16'h8000, 16'h8000, 0, 0, 1, 1, 0);
        2: program_regs(16'h7FFF, 16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF,
                        4096, 4096, 255);
        default:
          program_regs(16'($urandom_range(0, 16383) - 8192),
                       16'($urandom_range(0, 16383) - 8192),
                       16'($urandom_range(0, 16383) - 8192),
                       16'($urandom), 16'($urandom),
                       ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(1, 4096)),
                       ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(1, 4096)),
                       16'($urandom_range(0, 255)));
      endcase
      case (p % 4)
        0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1:       begin src_idle_pct = 80; sink_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  sink_stall_pct = 80; end
        default: begin src_idle_pct = 22; sink_stall_pct = 22; end
      endcase
      start_count = projected_count;
      while (projected_count - start_count < PhaseTarget) begin
        set_len = $urandom_range(1, 12);
        kind    = $urandom_range(0, 9);
        for (int k = 0; k < set_len; k++) begin
          px = 16'($urandom);
          py = 16'($urandom);
          pz = 16'($urandom);
          if (kind == 0) begin
            // whole set at or behind the near plane unless the 16 bit point depth wraps
            czr = int'(near_q) - int'($urandom_range(0, 600));
            pz  = 16'(int'(cam_z) + czr);
          end else if ($urandom_range(0, 4) != 0) begin
            czr = int'(near_q) + 1 + int'($urandom_range(0, 3000));
            cxr = int'($urandom_range(0, 2 * czr)) - czr;
            cyr = int'($urandom_range(0, 2 * czr)) - czr;
            px  = 16'(int'(cam_x) + cxr);
            py  = 16'(int'(cam_y) + cyr);
            pz  = 16'(int'(cam_z) + czr);
          end
          send_point(px, py, pz, k == set_len - 1);
        end
      end
      wait_idle();
    end
  endtask

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_defaults();
    test_near_limit();
    test_field_extremes();
    test_screen_limits();
    test_random_sets();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
